/* design/ssdk_pkg.sv */
// ssdk_pkg: shared types, sizes and the sort-key function for the digit-key shell sorter
// no dependencies; used by every module of the block except ssdk_ram
`timescale 1ns / 1ps

package ssdk_pkg;

  // capacity of the value store
  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // field widths
  localparam int VALUE_W = 7;
  localparam int KEY_W   = 4;
  localparam int STORE_W = KEY_W + VALUE_W;

  // reciprocal of ten for a 7-bit value: floor(v / 10) == (v * 205) >> 11
  localparam int RECIP_10    = 205;
  localparam int RECIP_SHIFT = 11;
  localparam int PROD_W      = VALUE_W + 8;

  // queue between the input stage and the sort engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_KEY_MODE = 2'd0;

  // key modes
  localparam logic KEY_MODE_TENS  = 1'b0;
  localparam logic KEY_MODE_UNITS = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] item_value;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               last_out;
    logic               dropped;
  } out_item_t;

  // one store entry: precomputed key next to the value
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } store_t;

  // one queue entry handed from the input stage to the sort engine
  typedef struct packed {
    store_t data;
    logic   last;
  } q_entry_t;

  // sort key: tens digit (value itself below ten) or units digit
  function automatic logic [KEY_W-1:0] key_of(input logic [VALUE_W-1:0] v, input logic mode);
    logic [PROD_W-1:0]  prod;
    logic [KEY_W-1:0]   tens;
    logic [VALUE_W-1:0] tens_x10;
    logic [VALUE_W-1:0] units;
    logic [KEY_W-1:0]   key;
    prod     = PROD_W'(v) * PROD_W'(RECIP_10);
    tens     = prod[RECIP_SHIFT +: KEY_W];
    tens_x10 = VALUE_W'(tens) * VALUE_W'(10);
    units    = v - tens_x10;
    if (mode == KEY_MODE_UNITS) begin
      key = units[KEY_W-1:0];
    end else if (tens == '0) begin
      key = v[KEY_W-1:0];
    end else begin
      key = tens;
    end
    return key;
  endfunction

endpackage

/* design/shell_sort_digit_key.sv */
// Digit-key shell sorter. Values enter through a queue-style port (push/full) and are
// stored one per cycle through a four-entry queue, so up to four further values are taken
// while the engine is busy. A transaction with last_in set closes the set: the engine
// shell-sorts the stored values with gaps n/2, n/4 .. 1 by gapped insertion, then pops the
// results out in order (empty/pop). Each compare step reads a pair of entries and compares
// their keys, and when it swaps it writes the two entries one after the other, as the value
// store has a single write port; the engine also steps through every insertion position and
// every gap pass. Up to 64 values are kept per set; further values are ignored and
// flagged on the dropped bit of every result of that set. key_mode (register 0, APB) selects
// the key: 0 the tens digit, or the value itself below ten; 1 the units digit. Change it
// only while the block is idle. No clearing pass is needed after reset.
// depends on ssdk_pkg, ssdk_front, ssdk_back
`timescale 1ns / 1ps

module shell_sort_digit_key (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           push,
  output logic                           full,
  input  ssdk_pkg::in_item_t             in_item,
  // result channel
  output logic                           empty,
  input  logic                           pop,
  output ssdk_pkg::out_item_t            out_item,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssdk_pkg::PADDR_W-1:0]   paddr,
  input  logic [ssdk_pkg::PDATA_W-1:0]   pwdata,
  output logic [ssdk_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic               key_mode_r, key_mode_nxt;
  logic               cfg_wr;
  logic               head_valid;
  ssdk_pkg::q_entry_t head;
  logic               head_pop;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == ssdk_pkg::REG_KEY_MODE) ? ssdk_pkg::PDATA_W'(key_mode_r) : '0;

  always_comb begin
    key_mode_nxt = key_mode_r;
    if (cfg_wr && paddr == ssdk_pkg::REG_KEY_MODE) begin
      key_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= ssdk_pkg::KEY_MODE_TENS;
    end else begin
      key_mode_r <= key_mode_nxt;
    end
  end

  // input stage and queue
  ssdk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .key_mode   (key_mode_r),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // sort engine and result register
  ssdk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule

/* design/ssdk_ram.sv */
// ssdk_ram: generic one-write, two-read memory with registered, enabled read data
// no dependencies
`timescale 1ns / 1ps

module ssdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read ports, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem_r[rd_addr_a];
      rd_data_b <= mem_r[rd_addr_b];
    end
  end

endmodule

/* design/ssdk_front.sv */
// ssdk_front: input stage; computes the sort key of each value and queues it for the engine
// depends on ssdk_pkg
`timescale 1ns / 1ps

module ssdk_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ssdk_pkg::in_item_t  in_item,
  input  logic                key_mode,
  output logic                head_valid,
  output ssdk_pkg::q_entry_t  head,
  input  logic                head_pop
);

  ssdk_pkg::q_entry_t                q_mem_r [ssdk_pkg::QUEUE_DEPTH];
  logic [ssdk_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ssdk_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ssdk_pkg::QCNT_W-1:0]       fill_r, fill_nxt;
  logic                              do_push;
  logic                              do_pop;
  ssdk_pkg::q_entry_t                new_entry;

  assign full       = (fill_r == ssdk_pkg::QCNT_W'(ssdk_pkg::QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head       = q_mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  // classify the incoming transaction
  always_comb begin
    new_entry.data.key   = ssdk_pkg::key_of(in_item.item_value, key_mode);
    new_entry.data.value = in_item.item_value;
    new_entry.last       = in_item.last_in;
  end

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ssdk_pkg::QPTR_W'(ssdk_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ssdk_pkg::QPTR_W'(ssdk_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

/* design/ssdk_back.sv */
// ssdk_back: sort engine; loads queued values into the store, shell-sorts them, emits results
// depends on ssdk_pkg and ssdk_ram
`timescale 1ns / 1ps

module ssdk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  ssdk_pkg::q_entry_t  head,
  output logic                head_pop,
  output logic                empty,
  input  logic                pop,
  output ssdk_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_NEXT_I,
    ST_RD,
    ST_CMP,
    ST_SWAP2,
    ST_EMIT_RD,
    ST_EMIT_LD
  } back_state_t;

  back_state_t                   state_r, state_nxt;
  logic [ssdk_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [ssdk_pkg::CNT_W-1:0]    n_r, n_nxt;
  logic [ssdk_pkg::ADDR_W-1:0]   gap_r, gap_nxt;
  logic [ssdk_pkg::CNT_W-1:0]    i_r, i_nxt;
  logic [ssdk_pkg::ADDR_W-1:0]   j_r, j_nxt;
  logic [ssdk_pkg::CNT_W-1:0]    k_r, k_nxt;
  ssdk_pkg::out_item_t           out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          wr_en;
  logic [ssdk_pkg::ADDR_W-1:0]   wr_addr;
  ssdk_pkg::store_t              wr_data;
  logic                          rd_en;
  logic [ssdk_pkg::ADDR_W-1:0]   rd_addr_a;
  logic [ssdk_pkg::ADDR_W-1:0]   rd_addr_b;
  ssdk_pkg::store_t              rd_data_a;
  ssdk_pkg::store_t              rd_data_b;
  logic [ssdk_pkg::ADDR_W-1:0]   j_far;
  logic                          room;
  logic                          out_free;

  assign empty    = !out_valid_r;
  assign out_item = out_r;
  assign j_far    = j_r + gap_r;
  assign room     = (count_r < ssdk_pkg::CNT_W'(ssdk_pkg::MAX_ITEMS));
  assign out_free = !out_valid_r || pop;
  assign head_pop = (state_r == ST_LOAD) && head_valid;

  // value store
  ssdk_ram #(
    .WIDTH (ssdk_pkg::STORE_W),
    .DEPTH (ssdk_pkg::MAX_ITEMS)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // store port selection
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = j_r;
    wr_data   = rd_data_b;
    rd_en     = 1'b0;
    rd_addr_a = j_r;
    rd_addr_b = j_far;
    case (state_r)
      ST_LOAD: begin
        wr_en   = head_valid && room;
        wr_addr = count_r[ssdk_pkg::ADDR_W-1:0];
        wr_data = head.data;
      end
      ST_RD: begin
        rd_en = 1'b1;
      end
      ST_CMP: begin
        wr_en = (rd_data_a.key > rd_data_b.key);
      end
      ST_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = j_far;
        wr_data = rd_data_a;
      end
      ST_EMIT_RD: begin
        rd_en     = out_free;
        rd_addr_a = k_r[ssdk_pkg::ADDR_W-1:0];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // sequencer: load, gap passes of gapped insertion, emit
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    gap_nxt       = gap_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    case (state_r)
      ST_LOAD: begin
        if (head_valid) begin
          if (room) begin
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (head.last) begin
            n_nxt     = count_nxt;
            gap_nxt   = count_nxt[ssdk_pkg::CNT_W-1:1];
            i_nxt     = ssdk_pkg::CNT_W'(count_nxt[ssdk_pkg::CNT_W-1:1]);
            state_nxt = ST_NEXT_I;
          end
        end
      end
      ST_NEXT_I: begin
        if (gap_r == '0) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end else if (i_r < n_r) begin
          j_nxt     = ssdk_pkg::ADDR_W'(i_r - ssdk_pkg::CNT_W'(gap_r));
          state_nxt = ST_RD;
        end else begin
          gap_nxt = gap_r >> 1;
          i_nxt   = ssdk_pkg::CNT_W'(gap_r >> 1);
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (rd_data_a.key > rd_data_b.key) begin
          state_nxt = ST_SWAP2;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_NEXT_I;
        end
      end
      ST_SWAP2: begin
        if (j_r >= gap_r) begin
          j_nxt     = j_r - gap_r;
          state_nxt = ST_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_NEXT_I;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        out_valid_nxt        = 1'b1;
        out_nxt.sorted_value = rd_data_a.value;
        out_nxt.last_out     = (k_r + 1'b1 == n_r);
        out_nxt.dropped      = ovf_r;
        k_nxt                = k_r + 1'b1;
        if (k_r + 1'b1 == n_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r   <= n_nxt;
    gap_r <= gap_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    out_r <= out_nxt;
  end

  // fill count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ssdk_pkg::CNT_W'(ssdk_pkg::MAX_ITEMS))
    else $error("store fill count beyond capacity");

  // a result is only loaded into an empty output register
  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_LD |-> !out_valid_r)
    else $error("result overwrites a waiting result");

  // a read for a compare step has a nonzero gap and both addresses inside the set
  a_rd_gap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> gap_r != '0 && ssdk_pkg::CNT_W'(j_far) < n_r)
    else $error("compare addresses outside the set");

  // the swap completes in the cycle after the compare that started it
  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWAP2 |-> $past(state_r) == ST_CMP && $past(wr_en))
    else $error("second half of swap without first half");

  // the queue is only drained while loading
  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> state_r == ST_LOAD && head_valid)
    else $error("queue popped outside the load phase");

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for the digit-key shell sorter, with its own sort predictor
// depends on ssdk_pkg and shell_sort_digit_key; a driver and a monitor run as clocked blocks
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_VALUES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic push = 1'b0;
  logic full;
  ssdk_pkg::in_item_t in_item = '0;

  // result channel
  logic empty;
  logic pop = 1'b0;
  ssdk_pkg::out_item_t out_item;

  // configuration port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ssdk_pkg::PADDR_W-1:0] paddr = '0;
  logic [ssdk_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ssdk_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // predictor state: a copy of the value store, fill count, overflow flag and key mode
  logic [ssdk_pkg::VALUE_W-1:0] shadow_store [ssdk_pkg::MAX_ITEMS];
  int unsigned shadow_count = 0;
  logic shadow_overflow = 1'b0;
  logic shadow_mode = ssdk_pkg::KEY_MODE_TENS;

  // values waiting to go in, sorted values waiting to come out
  ssdk_pkg::in_item_t values_to_send[$];
  ssdk_pkg::out_item_t sorted_due[$];

  // idling control and bookkeeping
  logic steady_send = 1'b0;
  logic steady_take = 1'b0;
  int unsigned send_wait = 0;
  int unsigned take_wait = 0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned values_queued = 0;
  int unsigned values_taken = 0;
  int unsigned sets_queued = 0;
  int unsigned largest_set = 0;
  int unsigned results_checked = 0;

  shell_sort_digit_key i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, sorted_due.size());
      $display("tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d (result %0d)",
             $realtime, what, got, want, results_checked);
    mismatches++;
  endtask

  // sort key: units digit, or tens digit (the value itself below ten)
  function automatic int unsigned digit_key(logic [ssdk_pkg::VALUE_W-1:0] v, logic mode);
    int unsigned tens;
    tens = v / 10;
    if (mode == ssdk_pkg::KEY_MODE_UNITS) return v % 10;
    return (tens == 0) ? int'(v) : tens;
  endfunction

  // store one accepted value; a last mark shell-sorts the set and queues its results
  task automatic absorb_value(ssdk_pkg::in_item_t it);
    int unsigned n;
    int unsigned gap;
    int unsigned i;
    int j;
    logic [ssdk_pkg::VALUE_W-1:0] tmp;
    ssdk_pkg::out_item_t r;
    values_taken++;
    if (shadow_count < ssdk_pkg::MAX_ITEMS) begin
      shadow_store[shadow_count] = it.item_value;
      shadow_count++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (it.last_in) begin
      n = shadow_count;
      for (gap = n / 2; gap > 0; gap = gap / 2) begin
        for (i = gap; i < n; i++) begin
          j = int'(i) - int'(gap);
          while (j >= 0 && digit_key(shadow_store[j], shadow_mode) >
                           digit_key(shadow_store[j + int'(gap)], shadow_mode)) begin
            tmp = shadow_store[j];
            shadow_store[j] = shadow_store[j + int'(gap)];
            shadow_store[j + int'(gap)] = tmp;
            j = j - int'(gap);
          end
        end
      end
      for (i = 0; i < n; i++) begin
        r.sorted_value = shadow_store[i];
        r.last_out     = (i + 1 == n);
        r.dropped      = shadow_overflow;
        sorted_due     = {sorted_due, r};
      end
      shadow_count    = 0;
      shadow_overflow = 1'b0;
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(logic steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: one transaction per handshake, random gaps between them
  always @(posedge clk) begin
    if (rst_n && push && !full) absorb_value(in_item);
    if (!rst_n || (push && full)) begin
      // hold the current transaction
    end else if (send_wait != 0) begin
      send_wait <= send_wait - 1;
      push <= 1'b0;
    end else if (values_to_send.size() != 0) begin
      in_item <= values_to_send.pop_front();
      push <= 1'b1;
      send_wait <= pick_gap(steady_send);
    end else begin
      push <= 1'b0;
    end
  end

  // monitor: compare each popped transaction with the oldest sorted value due
  always @(posedge clk) begin : result_monitor
    ssdk_pkg::out_item_t want;
    int unsigned g;
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop && !empty) begin
      if (sorted_due.size() == 0) begin
        report_mismatch("unexpected result, value", out_item.sorted_value, 0);
      end else begin
        want = sorted_due.pop_front();
        if (out_item.sorted_value !== want.sorted_value)
          report_mismatch("sorted_value", out_item.sorted_value, want.sorted_value);
        if (out_item.last_out !== want.last_out)
          report_mismatch("last_out", out_item.last_out, want.last_out);
        if (out_item.dropped !== want.dropped)
          report_mismatch("dropped", out_item.dropped, want.dropped);
      end
      results_checked++;
      g = pick_gap(steady_take);
      take_wait <= g;
      pop <= (g == 0);
    end else if (take_wait != 0) begin
      take_wait <= take_wait - 1;
      pop <= (take_wait == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  // register write, then read back
  task automatic write_key_mode(logic m);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ssdk_pkg::REG_KEY_MODE;
    pwdata  <= ssdk_pkg::PDATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_mode = m;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== ssdk_pkg::PDATA_W'(m)) report_mismatch("key_mode readback", prdata, m);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_value(int unsigned v, logic last);
    ssdk_pkg::in_item_t it;
    it.item_value = ssdk_pkg::VALUE_W'(v);
    it.last_in    = last;
    values_to_send = {values_to_send, it};
    values_queued++;
  endtask

  // one set of random values, last mark on the final one
  task automatic queue_set(int unsigned len);
    int unsigned k;
    int unsigned v;
    for (k = 0; k < len; k++) begin
      v = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 99) : $urandom_range(0, 127);
      queue_value(v, k + 1 == len);
    end
    sets_queued++;
    if (len > largest_set) largest_set = len;
  endtask

  function automatic int unsigned rand_set_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 84) return $urandom_range(1, 10);
    if (r < 96) return $urandom_range(11, 40);
    return $urandom_range(ssdk_pkg::MAX_ITEMS - 4, ssdk_pkg::MAX_ITEMS + 6);
  endfunction

  // wait until every value has been sent and every due result has been popped, then let the block settle
  task automatic wait_drained();
    while (values_to_send.size() != 0 || push || sorted_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed, tens-digit key: field extremes, values above 99, single value, equal keys
    write_key_mode(ssdk_pkg::KEY_MODE_TENS);
    queue_value(127, 1'b0);
    queue_value(0, 1'b0);
    queue_value(9, 1'b0);
    queue_value(10, 1'b0);
    queue_value(99, 1'b0);
    queue_value(100, 1'b0);
    queue_value(119, 1'b0);
    queue_value(120, 1'b0);
    queue_value(55, 1'b0);
    queue_value(5, 1'b1);
    queue_value(42, 1'b1);
    queue_value(10, 1'b0);
    queue_value(19, 1'b0);
    queue_value(11, 1'b1);
    sets_queued += 3;
    wait_drained();

    // directed, units-digit key
    write_key_mode(ssdk_pkg::KEY_MODE_UNITS);
    queue_value(19, 1'b0);
    queue_value(29, 1'b0);
    queue_value(9, 1'b0);
    queue_value(127, 1'b0);
    queue_value(0, 1'b0);
    queue_value(10, 1'b0);
    queue_value(73, 1'b0);
    queue_value(33, 1'b1);
    sets_queued++;
    wait_drained();

    // random phases, alternating key mode; an exactly full set and an overflowing set are always included
    for (phase = 0; phase < 6; phase++) begin
      write_key_mode(phase[0] ? ssdk_pkg::KEY_MODE_UNITS : ssdk_pkg::KEY_MODE_TENS);
      steady_send = (phase == 2) || ($urandom_range(0, 3) == 0);
      steady_take = (phase == 2) || ($urandom_range(0, 3) == 0);
      start = values_queued;
      if (phase == 1) queue_set(ssdk_pkg::MAX_ITEMS);
      if (phase == 4) queue_set(ssdk_pkg::MAX_ITEMS + 2);
      while (values_queued - start < PHASE_VALUES) queue_set(rand_set_len());
      wait_drained();
    end

    $display("covered %0d values in %0d sets (largest %0d) under both key modes",
             values_taken, sets_queued, largest_set);
    $display("checked %0d sorted results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
